@@ design/mmi_pkg.sv @@
// shared constants, types and state codes for the montgomery inverse block
package mmi_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned HighBits = 62;
  localparam int unsigned NumBits  = 2 * WordBits;
  localparam int unsigned AccBits  = 3 * WordBits;
  localparam int unsigned DigBits  = 32;
  localparam int unsigned ShBits   = 7;
  localparam int unsigned TBits    = 10;
  localparam int unsigned CfgIdxBits = 2;

  typedef logic [NumBits-1:0] num_t;

  // configuration register indexes
  localparam logic [CfgIdxBits-1:0] CfgModLow  = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgModHigh = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgNegInv  = 2'd2;

  // request to the reduction unit
  typedef struct packed {
    logic                start;
    num_t                x;
    logic [ShBits-1:0]   n;
    num_t                m;
    logic [WordBits-1:0] invm;
  } redc_req_t;

  // response of the reduction unit
  typedef struct packed {
    logic done;
    num_t result;
  } redc_rsp_t;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_KMUL,
    RS_KACC,
    RS_MMUL,
    RS_MACC,
    RS_DONE
  } redc_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE,
    S_PREW,
    S_PRECHK,
    S_ASH,
    S_SUB1,
    S_SH1,
    S_SUB2,
    S_SH2,
    S_END,
    S_TCHK,
    S_TW,
    S_NEG,
    S_DBL,
    S_FIN
  } main_state_e;

endpackage

@@ design/montgomery_modular_inverse_core.sv @@
// top level of the montgomery modular inverse block
//
// Input channel: value_low_i/value_high_i with in_valid_i; a beat is taken
// when in_valid_i is high and in_stall_o is low. in_stall_o is high while an
// item is being worked on, so one item is in flight at a time.
// Output channel: inverse_low_o/inverse_high_o/invertible_o with out_valid_o;
// the receiver holds a beat with out_stall_i. The result sits in an output
// register, so a new item is taken while an old result still waits.
// Latency is data dependent and shorter for small moduli: three reductions
// on the shared 32x32 multiplier, a subtract plus an odd check per subtract
// step, one shift step per bit shifted in the binary gcd, up to three more
// reductions for the shift count, and one doubling step per bit when the
// count is negative. Inputs rejected up front go straight to the finish
// state.
// Configuration writes go through cfg_we_i, cfg_index_i and cfg_data_i and
// take effect at once; write only while idle.
// Reset sets the modulus to one and the negated inverse to all ones, and
// empties the pipeline and output register.
module montgomery_modular_inverse_core (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [mmi_pkg::CfgIdxBits-1:0]        cfg_index_i,
  input  logic [mmi_pkg::WordBits-1:0]          cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic [mmi_pkg::WordBits-1:0]          value_low_i,
  input  logic [mmi_pkg::HighBits-1:0]          value_high_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic [mmi_pkg::WordBits-1:0]          inverse_low_o,
  output logic [mmi_pkg::HighBits-1:0]          inverse_high_o,
  output logic                                  invertible_o
);

  mmi_pkg::main_state_e state_q, state_d;

  logic [mmi_pkg::WordBits-1:0] mlo_q, invm_q;
  logic [mmi_pkg::HighBits-1:0] mhi_q;

  mmi_pkg::num_t a_q, b_q, u_q, v_q;
  logic signed [mmi_pkg::TBits-1:0] t_q;
  logic [1:0] cnt_q;
  logic       ok_q;

  logic                         out_valid_q, out_ok_q;
  logic [mmi_pkg::WordBits-1:0] out_lo_q;
  logic [mmi_pkg::HighBits-1:0] out_hi_q;

  mmi_pkg::redc_req_t redc_req;
  mmi_pkg::redc_rsp_t redc_rsp;

  mmi_pkg::num_t m, in_val, u_sub, u_dbl, u_dbl_r;
  logic in_acc, in_fail, out_free;
  logic a_lt_b, b_lt_a, a_eq_b, u_ge_m, dbl_ge_m;
  logic t_ge_word, t_pos, t_neg;
  logic [mmi_pkg::ShBits-1:0] tn;

  assign m      = {2'b0, mhi_q, mlo_q};
  assign in_val = {2'b0, value_high_i, value_low_i};
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_fail = !mlo_q[0] || !(in_val < m) || (in_val == '0);
  assign out_free = !out_valid_q || !out_stall_i;

  // shared compare and subtract logic
  assign a_lt_b   = a_q < b_q;
  assign b_lt_a   = b_q < a_q;
  assign a_eq_b   = a_q == b_q;
  assign u_ge_m   = !(u_q < m);
  assign u_sub    = u_ge_m ? u_q - m : u_q;
  assign u_dbl    = u_q << 1;
  assign dbl_ge_m = !(u_dbl < m);
  assign u_dbl_r  = dbl_ge_m ? u_dbl - m : u_dbl;

  assign t_ge_word = t_q >= $signed(10'd64);
  assign t_pos     = t_q > $signed(10'd0);
  assign t_neg     = t_q < $signed(10'd0);
  assign tn        = t_ge_word ? 7'd64 : t_q[mmi_pkg::ShBits-1:0];

  // reduction unit request
  always_comb begin
    redc_req.start = (state_q == mmi_pkg::S_PRE) ||
                     ((state_q == mmi_pkg::S_TCHK) && ok_q && t_pos);
    redc_req.x     = (state_q == mmi_pkg::S_PRE) ? a_q : u_q;
    redc_req.n     = (state_q == mmi_pkg::S_PRE) ? 7'd64 : tn;
    redc_req.m     = m;
    redc_req.invm  = invm_q;
  end

  mmi_redc u_redc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (redc_req),
    .rsp_o  (redc_rsp)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mlo_q  <= 64'd1;
      mhi_q  <= '0;
      invm_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mmi_pkg::CfgModLow:  mlo_q  <= cfg_data_i;
        mmi_pkg::CfgModHigh: mhi_q  <= cfg_data_i[mmi_pkg::HighBits-1:0];
        mmi_pkg::CfgNegInv:  invm_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmi_pkg::S_IDLE:   if (in_acc) state_d = in_fail ? mmi_pkg::S_FIN : mmi_pkg::S_PRE;
      mmi_pkg::S_PRE:    state_d = mmi_pkg::S_PREW;
      mmi_pkg::S_PREW: begin
        if (redc_rsp.done) state_d = (cnt_q == 2'd2) ? mmi_pkg::S_PRECHK : mmi_pkg::S_PRE;
      end
      mmi_pkg::S_PRECHK: begin
        state_d = ((a_q == '0) || !(a_q < m)) ? mmi_pkg::S_FIN : mmi_pkg::S_ASH;
      end
      mmi_pkg::S_ASH:    if (a_q[0]) state_d = mmi_pkg::S_SUB1;
      mmi_pkg::S_SUB1:   state_d = mmi_pkg::S_SH1;
      mmi_pkg::S_SH1: begin
        if (b_q[0]) begin
          if (a_lt_b)      state_d = mmi_pkg::S_SUB1;
          else if (a_eq_b) state_d = mmi_pkg::S_END;
          else             state_d = mmi_pkg::S_SUB2;
        end
      end
      mmi_pkg::S_SUB2:   state_d = mmi_pkg::S_SH2;
      mmi_pkg::S_SH2: begin
        if (a_q[0]) begin
          if (b_lt_a)      state_d = mmi_pkg::S_SUB2;
          else if (a_eq_b) state_d = mmi_pkg::S_END;
          else             state_d = mmi_pkg::S_SUB1;
        end
      end
      mmi_pkg::S_END:    state_d = (a_q == 128'd1) ? mmi_pkg::S_TCHK : mmi_pkg::S_FIN;
      mmi_pkg::S_TCHK: begin
        if (t_pos)      state_d = mmi_pkg::S_TW;
        else if (t_neg) state_d = mmi_pkg::S_NEG;
        else            state_d = mmi_pkg::S_FIN;
      end
      mmi_pkg::S_TW:     if (redc_rsp.done) state_d = mmi_pkg::S_TCHK;
      mmi_pkg::S_NEG:    state_d = mmi_pkg::S_DBL;
      mmi_pkg::S_DBL:    if (t_q == $signed(-10'sd1)) state_d = mmi_pkg::S_FIN;
      mmi_pkg::S_FIN:    if (out_free) state_d = mmi_pkg::S_IDLE;
      default:           state_d = mmi_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmi_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      mmi_pkg::S_IDLE: begin
        if (in_acc) begin
          a_q   <= in_val;
          cnt_q <= '0;
          ok_q  <= !in_fail;
        end
      end
      mmi_pkg::S_PREW: begin
        if (redc_rsp.done) begin
          a_q   <= redc_rsp.result;
          cnt_q <= cnt_q + 2'd1;
        end
      end
      mmi_pkg::S_PRECHK: begin
        if ((a_q == '0) || !(a_q < m)) ok_q <= 1'b0;
        t_q <= -10'sd64;
        b_q <= m;
        u_q <= 128'd1;
        v_q <= '0;
      end
      mmi_pkg::S_ASH: begin
        if (!a_q[0]) begin
          a_q <= a_q >> 1;
          t_q <= t_q + 10'sd1;
        end
      end
      mmi_pkg::S_SUB1: begin
        b_q <= b_q - a_q;
        v_q <= v_q + u_q;
      end
      mmi_pkg::S_SH1: begin
        if (!b_q[0]) begin
          b_q <= b_q >> 1;
          u_q <= u_q << 1;
          t_q <= t_q + 10'sd1;
        end
      end
      mmi_pkg::S_SUB2: begin
        a_q <= a_q - b_q;
        u_q <= u_q + v_q;
      end
      mmi_pkg::S_SH2: begin
        if (!a_q[0]) begin
          a_q <= a_q >> 1;
          v_q <= v_q << 1;
          t_q <= t_q + 10'sd1;
        end
      end
      mmi_pkg::S_END: begin
        if (a_q != 128'd1) ok_q <= 1'b0;
      end
      mmi_pkg::S_TCHK: begin
        if (t_pos) t_q <= t_q - $signed({3'b0, tn});
      end
      mmi_pkg::S_TW: begin
        if (redc_rsp.done) u_q <= redc_rsp.result;
      end
      mmi_pkg::S_NEG: begin
        u_q <= u_sub;
      end
      mmi_pkg::S_DBL: begin
        u_q <= u_dbl_r;
        t_q <= t_q + 10'sd1;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == mmi_pkg::S_FIN && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == mmi_pkg::S_FIN && out_free) begin
      out_ok_q <= ok_q;
      out_lo_q <= ok_q ? u_sub[63:0] : '0;
      out_hi_q <= ok_q ? u_sub[125:64] : '0;
    end
  end

  assign in_stall_o     = (state_q != mmi_pkg::S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign inverse_low_o  = out_lo_q;
  assign inverse_high_o = out_hi_q;
  assign invertible_o   = out_ok_q;

endmodule

@@ design/mmi_redc.sv @@
// variable width montgomery reduction (x + k*m) >> n on a shared 32x32 multiplier
module mmi_redc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mmi_pkg::redc_req_t req_i,
  output mmi_pkg::redc_rsp_t rsp_o
);

  mmi_pkg::redc_state_e state_q, state_d;

  logic [mmi_pkg::AccBits-1:0]  acc_q;
  logic [mmi_pkg::ShBits-1:0]   n_q;
  logic [mmi_pkg::WordBits-1:0] k_q;
  logic [mmi_pkg::WordBits-1:0] p_q;
  logic [2:0]                   sh_q;
  logic [2:0]                   idx_q;
  mmi_pkg::num_t                m_q;
  logic [mmi_pkg::WordBits-1:0] invm_q;

  logic [mmi_pkg::DigBits-1:0]  opa, opb;
  logic [2:0]                   sh_sel;
  logic [mmi_pkg::WordBits-1:0] kmask;
  logic [mmi_pkg::WordBits-1:0] ksum;
  logic [mmi_pkg::AccBits-1:0]  shifted;

  // operand selection for the current partial product
  always_comb begin
    opa    = '0;
    opb    = '0;
    sh_sel = '0;
    case (state_q)
      mmi_pkg::RS_KMUL: begin
        opa    = (idx_q == 3'd2) ? acc_q[63:32] : acc_q[31:0];
        opb    = (idx_q == 3'd1) ? invm_q[63:32] : invm_q[31:0];
        sh_sel = (idx_q == 3'd0) ? 3'd0 : 3'd1;
      end
      mmi_pkg::RS_MMUL: begin
        opa    = idx_q[2] ? k_q[63:32] : k_q[31:0];
        opb    = m_q[{idx_q[1:0], 5'd0} +: mmi_pkg::DigBits];
        sh_sel = {2'b0, idx_q[2]} + {1'b0, idx_q[1:0]};
      end
      default: begin
        opa    = '0;
        opb    = '0;
        sh_sel = '0;
      end
    endcase
  end

  // masks and shifted partial products
  assign kmask   = ~({mmi_pkg::WordBits{1'b1}} << n_q);
  assign ksum    = k_q + (p_q << {sh_q[0], 5'd0});
  assign shifted = {{mmi_pkg::WordBits{1'b0}}, {mmi_pkg::WordBits{1'b0}}, p_q}
                   << {sh_q, 5'd0};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mmi_pkg::RS_IDLE: if (req_i.start) state_d = mmi_pkg::RS_KMUL;
      mmi_pkg::RS_KMUL: state_d = mmi_pkg::RS_KACC;
      mmi_pkg::RS_KACC: state_d = (idx_q == 3'd2) ? mmi_pkg::RS_MMUL : mmi_pkg::RS_KMUL;
      mmi_pkg::RS_MMUL: state_d = mmi_pkg::RS_MACC;
      mmi_pkg::RS_MACC: state_d = (idx_q == 3'd7) ? mmi_pkg::RS_DONE : mmi_pkg::RS_MMUL;
      mmi_pkg::RS_DONE: state_d = mmi_pkg::RS_IDLE;
      default:          state_d = mmi_pkg::RS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmi_pkg::RS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      mmi_pkg::RS_IDLE: begin
        if (req_i.start) begin
          acc_q  <= {{mmi_pkg::WordBits{1'b0}}, req_i.x};
          n_q    <= req_i.n;
          m_q    <= req_i.m;
          invm_q <= req_i.invm;
          k_q    <= '0;
          idx_q  <= '0;
        end
      end
      mmi_pkg::RS_KMUL, mmi_pkg::RS_MMUL: begin
        p_q  <= opa * opb;
        sh_q <= sh_sel;
      end
      mmi_pkg::RS_KACC: begin
        if (idx_q == 3'd2) begin
          k_q   <= ksum & kmask;
          idx_q <= '0;
        end else begin
          k_q   <= ksum;
          idx_q <= idx_q + 3'd1;
        end
      end
      mmi_pkg::RS_MACC: begin
        acc_q <= acc_q + shifted;
        idx_q <= idx_q + 3'd1;
      end
      default: begin
      end
    endcase
  end

  logic [mmi_pkg::AccBits-1:0] acc_sh;
  assign acc_sh        = acc_q >> n_q;
  assign rsp_o.done    = (state_q == mmi_pkg::RS_DONE);
  assign rsp_o.result  = acc_sh[mmi_pkg::NumBits-1:0];

endmodule

@@ verif/mmi_inverse_checker.sv @@
// checker for the montgomery inverse block: predicts each beat and compares results
`timescale 1ns / 100ps

module mmi_inverse_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mmi_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [mmi_pkg::WordBits-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [mmi_pkg::WordBits-1:0]   value_low_i,
  input  logic [mmi_pkg::HighBits-1:0]   value_high_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [mmi_pkg::WordBits-1:0]   inverse_low_i,
  input  logic [mmi_pkg::HighBits-1:0]   inverse_high_i,
  input  logic                           invertible_i,
  output int                             fail_count_o,
  output int                             waiting_o,
  output int                             results_o,
  output int                             passes_o
);

  typedef struct {
    logic [mmi_pkg::WordBits-1:0] inv_low;
    logic [mmi_pkg::HighBits-1:0] inv_high;
    logic                         ok;
  } inverse_t;

  logic [mmi_pkg::WordBits-1:0] mod_low;
  logic [mmi_pkg::HighBits-1:0] mod_high;
  logic [mmi_pkg::WordBits-1:0] neg_inv;
  inverse_t                     inverse_q[$];

  // (x + k*m) >> n with k taken from the low n bits of x * neg_inv
  function automatic logic [127:0] mont_reduce(logic [127:0] x, int n, logic [127:0] m);
    logic [63:0]  k;
    logic [191:0] s;
    k = x[63:0] * neg_inv;
    if (n < 64) k = k & ((64'd1 << n) - 64'd1);
    s = 192'(x) + 192'(k) * 192'(m);
    s = s >> n;
    return s[127:0];
  endfunction

  function automatic int trailing_zeros(logic [127:0] x);
    int c;
    c = 0;
    if (x == 0) return 0;
    while (!x[c]) c++;
    return c;
  endfunction

  function automatic inverse_t predict_inverse(logic [127:0] val);
    inverse_t     r;
    logic [127:0] m, a, b, u, v;
    int           t, n;
    r = '{inv_low: '0, inv_high: '0, ok: 1'b0};
    m = {2'b00, mod_high, mod_low};
    if (!m[0] || val >= m || val == 0) return r;
    a = mont_reduce(val, 64, m);
    a = mont_reduce(a, 64, m);
    a = mont_reduce(a, 64, m);
    if (a == 0 || a >= m) return r;
    t = -64;
    n = trailing_zeros(a);
    a = a >> n;
    t += n;
    b = m;
    u = 128'd1;
    v = 128'd0;
    // binary extended gcd with running shift count
    do begin
      do begin
        b = b - a;
        v = v + u;
        n = trailing_zeros(b);
        b = b >> n;
        u = u << n;
        t += n;
      end while (a < b);
      if (a == b) break;
      do begin
        a = a - b;
        u = u + v;
        n = trailing_zeros(a);
        a = a >> n;
        v = v << n;
        t += n;
      end while (b < a);
    end while (a != b);
    if (a != 128'd1) return r;
    while (t >= 64) begin
      u = mont_reduce(u, 64, m);
      t -= 64;
    end
    if (t > 0) begin
      u = mont_reduce(u, t, m);
    end else if (t < 0) begin
      // small modulus: double back the missing bits
      if (u >= m) u = u - m;
      while (t < 0) begin
        u = u << 1;
        if (u >= m) u = u - m;
        t++;
      end
    end
    if (u >= m) u = u - m;
    r.inv_low  = u[63:0];
    r.inv_high = u[125:64];
    r.ok       = 1'b1;
    return r;
  endfunction

  assign waiting_o = inverse_q.size();

  // track registers, predict input beats, compare output beats
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t e;
    if (!rst_ni) begin
      mod_low      <= 64'd1;
      mod_high     <= '0;
      neg_inv      <= '1;
      fail_count_o <= 0;
      results_o    <= 0;
      passes_o     <= 0;
      inverse_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          mmi_pkg::CfgModLow:  mod_low  <= cfg_data_i;
          mmi_pkg::CfgModHigh: mod_high <= cfg_data_i[mmi_pkg::HighBits-1:0];
          mmi_pkg::CfgNegInv:  neg_inv  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        inverse_q.push_back(predict_inverse({2'b00, value_high_i, value_low_i}));
      if (out_valid_i && !out_stall_i) begin
        results_o <= results_o + 1;
        if (inverse_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = inverse_q.pop_front();
          if (e.ok) passes_o <= passes_o + 1;
          if (e.inv_low !== inverse_low_i || e.inv_high !== inverse_high_i ||
              e.ok !== invertible_i) begin
            fail_count_o <= fail_count_o + 1;
            if (e.inv_low !== inverse_low_i)
              $error("inverse_low expected %h actual %h", e.inv_low, inverse_low_i);
            if (e.inv_high !== inverse_high_i)
              $error("inverse_high expected %h actual %h", e.inv_high, inverse_high_i);
            if (e.ok !== invertible_i)
              $error("invertible expected %b actual %b", e.ok, invertible_i);
          end
        end
      end
    end
  end

endmodule

@@ verif/montgomery_modular_inverse_core_test.sv @@
// stimulus and verdict for the montgomery modular inverse block
`timescale 1ns / 100ps

module montgomery_modular_inverse_core_test;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [mmi_pkg::CfgIdxBits-1:0] cfg_index_i = mmi_pkg::CfgModLow;
  logic [mmi_pkg::WordBits-1:0]   cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [mmi_pkg::WordBits-1:0]   value_low_i = '0;
  logic [mmi_pkg::HighBits-1:0]   value_high_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [mmi_pkg::WordBits-1:0]   inverse_low_o;
  logic [mmi_pkg::HighBits-1:0]   inverse_high_o;
  logic                           invertible_o;

  int           fail_count, waiting, results, passes;
  int           items_sent = 0;
  int           settings_used = 0;
  bit           calm = 1'b0;
  bit           hold_req = 1'b0;
  logic [127:0] modulus = 128'd1;

  montgomery_modular_inverse_core dut (.*);

  mmi_inverse_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .value_low_i, .value_high_i,
    .out_valid_i(out_valid_o), .out_stall_i, .inverse_low_i(inverse_low_o),
    .inverse_high_i(inverse_high_o), .invertible_i(invertible_o),
    .fail_count_o(fail_count), .waiting_o(waiting), .results_o(results),
    .passes_o(passes)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #60_000_000;
    $display("montgomery_modular_inverse_core_test: errors");
    $finish;
  end

  // receiver: random stall bursts, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
        hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic logic [127:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // minus inverse of an odd modulus mod 2^64 by newton steps
  function automatic logic [63:0] neg_inverse(logic [63:0] m);
    logic [63:0] x;
    x = m;
    repeat (6) x = x * (64'd2 - m * x);
    return -x;
  endfunction

  // let the checker see the last accepted beat before looking at the count
  task automatic drain();
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (1000) @(posedge clk_i);
  endtask

  task automatic set_modulus(logic [127:0] m, logic [63:0] ninv);
    drain();
    modulus = m;
    settings_used++;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= mmi_pkg::CfgModLow;
    cfg_data_i  <= m[63:0];
    @(posedge clk_i);
    cfg_index_i <= mmi_pkg::CfgModHigh;
    cfg_data_i  <= 64'(m[125:64]);
    @(posedge clk_i);
    cfg_index_i <= mmi_pkg::CfgNegInv;
    cfg_data_i  <= ninv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_value(logic [127:0] a);
    in_valid_i   <= 1'b1;
    value_low_i  <= a[63:0];
    value_high_i <= a[125:64];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // mostly residues below the modulus, some edge values and out-of-range beats
  function automatic logic [127:0] pick_value();
    logic [127:0] r;
    r = rand_wide();
    r[127:126] = 2'b00;
    case ($urandom_range(0, 11))
      0: return r;
      1: return 128'd0;
      2: return 128'd1;
      3: return modulus - 1;
      4: return (modulus % 3 == 0) ? (3 * (r % (modulus / 3))) : r % modulus;
      5: return {2'b00, {126{1'b1}}};
      default: return r % modulus;
    endcase
  endfunction

  function automatic logic [127:0] rand_modulus(int len);
    logic [127:0] m;
    m = rand_wide() >> (128 - len);
    m[len-1] = 1'b1;
    m[0] = 1'b1;
    return m;
  endfunction

  initial begin
    logic [127:0] m;
    logic [127:0] w;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset modulus of one: everything fails
    send_value(128'd0);
    send_value({2'b00, {126{1'b1}}});
    send_value(128'd5);
    in_valid_i <= 1'b0;

    // largest odd modulus
    m = {2'b00, {126{1'b1}}};
    set_modulus(m, neg_inverse(m[63:0]));
    send_value(128'd0);
    send_value(128'd1);
    send_value(128'd2);
    send_value(m - 1);
    send_value(m);
    send_value({2'b00, 62'h2aaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555});
    send_value({2'b00, 62'h1555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa});
    // long receiver hold while beats keep coming
    hold_req = 1'b1;
    repeat (6) send_value(pick_value());
    in_valid_i <= 1'b0;

    // tiny moduli, negative shift count
    set_modulus(128'd3, neg_inverse(64'd3));
    send_value(128'd1);
    send_value(128'd2);
    send_value(128'd3);
    in_valid_i <= 1'b0;
    set_modulus(128'd5, neg_inverse(64'd5));
    for (int i = 0; i < 5; i++) send_value(128'(i));
    in_valid_i <= 1'b0;

    // even modulus and a wrong inverse register
    set_modulus(128'd1000, 64'd7);
    send_value(128'd3);
    send_value(128'd999);
    in_valid_i <= 1'b0;
    m = rand_modulus(100);
    w = rand_wide();
    set_modulus(m, w[63:0]);
    repeat (20) send_value(pick_value());
    in_valid_i <= 1'b0;

    // random moduli of random size, some with a factor of three
    for (int p = 0; p < 28; p++) begin
      m = rand_modulus($urandom_range(2, 126));
      if (p % 4 == 1) m = rand_modulus($urandom_range(2, 124)) * 3;
      if (p == 27) begin
        m = rand_modulus(126);
        calm = 1'b1;
      end
      set_modulus(m, neg_inverse(m[63:0]));
      repeat (25) send_value(pick_value());
      in_valid_i <= 1'b0;
    end

    drain();
    $display("covered %0d beats over %0d register settings, %0d results, %0d invertible",
             items_sent, settings_used, results, passes);
    if (fail_count == 0) begin
      $display("montgomery_modular_inverse_core_test: clean");
    end else begin
      $display("montgomery_modular_inverse_core_test: errors");
    end
    $finish;
  end

endmodule

@@ montgomery_modular_inverse_core.f @@
design/mmi_pkg.sv
design/mmi_redc.sv
design/montgomery_modular_inverse_core.sv
verif/mmi_inverse_checker.sv
verif/montgomery_modular_inverse_core_test.sv
